@@ hw/rtl/tmq_pkg.sv @@
`timescale 1ns / 1ps

package tmq_pkg;

    localparam int SLOTS         = 16;
    localparam int MESSAGE_BYTES = 64;
    localparam int NONCE_BYTES   = 8;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int LEN_W   = $clog2(MESSAGE_BYTES + 1);
    localparam int IDX_W   = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
    localparam int NONCE_W = 8 * NONCE_BYTES;
    localparam int MSG_DEPTH = SLOTS * MESSAGE_BYTES;
    localparam int MSG_AW  = $clog2(MSG_DEPTH);

    localparam logic [2:0] REQ_ADD       = 3'd0;
    localparam logic [2:0] REQ_ENCRYPTED = 3'd1;
    localparam logic [2:0] REQ_REMOVE    = 3'd2;
    localparam logic [2:0] REQ_READ      = 3'd3;
    localparam logic [2:0] REQ_SET_NONCE = 3'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  data_byte;
        logic        byte_last;
        logic [63:0] nonce_in;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [7:0]  out_byte;
        logic        out_last;
        logic [63:0] out_nonce;
        logic [4:0]  pending_encrypt;
        logic [4:0]  pending_send;
    } t_rsp;

    typedef struct packed {
        logic               msg_we;
        logic [MSG_AW-1:0]  msg_waddr;
        logic [7:0]         msg_wdata;
        logic               msg_re;
        logic [MSG_AW-1:0]  msg_raddr;
        logic               len_we;
        logic [SLOT_W-1:0]  len_waddr;
        logic [LEN_W-1:0]   len_wdata;
        logic               nonce_we;
        logic [SLOT_W-1:0]  nonce_waddr;
        logic [NONCE_W-1:0] nonce_wdata;
        logic               slot_re;
        logic [SLOT_W-1:0]  slot_raddr;
    } t_mem_cmd;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(SLOTS - 1)) begin
            res = '0;
        end else begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

    function automatic logic [MSG_AW-1:0] msg_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [IDX_W-1:0]  idx);
        return MSG_AW'(slot) * MSG_AW'(MESSAGE_BYTES) + MSG_AW'(idx);
    endfunction

endpackage

@@ hw/rtl/tmq_ram.sv @@
`timescale 1ns / 1ps

module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tmq_ctrl.sv @@
`timescale 1ns / 1ps

module tmq_ctrl
    import tmq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_req               i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_rsp               o_out_data,
    output t_mem_cmd           o_mem,
    input  logic [7:0]         i_msg_rdata,
    input  logic [LEN_W-1:0]   i_len_rdata,
    input  logic [NONCE_W-1:0] i_nonce_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_BYTE = 2'd2;

    logic [1:0]        r_state,     n_state;
    logic [SLOT_W-1:0] r_add_slot,  n_add_slot;
    logic [SLOT_W-1:0] r_enc_slot,  n_enc_slot;
    logic [SLOT_W-1:0] r_send_slot, n_send_slot;
    logic [CNT_W-1:0]  r_enc_cnt,   n_enc_cnt;
    logic [CNT_W-1:0]  r_send_cnt,  n_send_cnt;
    logic [LEN_W-1:0]  r_bytes,     n_bytes;
    logic              r_too_long,  n_too_long;
    logic [IDX_W-1:0]  r_idx,       n_idx;
    t_rsp              r_out,       n_out;
    logic              r_out_valid;

    logic              out_free;
    logic              in_acc;
    logic              load;
    logic              full;
    logic              take;
    logic              too_long_upd;
    logic              status;
    logic              is_last;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign full = (SUM_W'(r_enc_cnt) + SUM_W'(r_send_cnt)) >= SUM_W'(SLOTS);
    assign take = !full && (r_bytes < LEN_W'(MESSAGE_BYTES));
    assign too_long_upd = r_too_long || !take;
    assign is_last = (LEN_W'(r_idx) + LEN_W'(1)) >= i_len_rdata;

    always_comb begin
        n_state     = r_state;
        n_add_slot  = r_add_slot;
        n_enc_slot  = r_enc_slot;
        n_send_slot = r_send_slot;
        n_enc_cnt   = r_enc_cnt;
        n_send_cnt  = r_send_cnt;
        n_bytes     = r_bytes;
        n_too_long  = r_too_long;
        n_idx       = r_idx;
        o_mem       = '0;
        load        = 1'b0;
        status      = STATUS_OK;
        n_out       = '0;

        o_mem.msg_waddr   = msg_addr(r_add_slot, r_bytes[IDX_W-1:0]);
        o_mem.msg_wdata   = i_in_data.data_byte;
        o_mem.len_waddr   = r_add_slot;
        o_mem.nonce_waddr = r_enc_slot;
        o_mem.nonce_wdata = i_in_data.nonce_in[NONCE_W-1:0];
        o_mem.slot_raddr  = r_send_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    load = 1'b1;
                    unique case (i_in_data.req_type)
                        REQ_ADD: begin
                            o_mem.msg_we = take;
                            n_bytes      = r_bytes + LEN_W'(take);
                            n_too_long   = too_long_upd;
                            if (i_in_data.byte_last) begin
                                if (too_long_upd) begin
                                    status = STATUS_ERR;
                                end else begin
                                    o_mem.len_we    = 1'b1;
                                    o_mem.len_wdata = n_bytes;
                                    n_add_slot      = next_slot(r_add_slot);
                                    n_enc_cnt       = r_enc_cnt + CNT_W'(1);
                                end
                                n_bytes    = '0;
                                n_too_long = 1'b0;
                            end
                        end
                        REQ_ENCRYPTED: begin
                            if (r_enc_cnt == '0) begin
                                status = STATUS_ERR;
                            end else begin
                                o_mem.nonce_we = 1'b1;
                                n_enc_slot     = next_slot(r_enc_slot);
                                n_enc_cnt      = r_enc_cnt - CNT_W'(1);
                                n_send_cnt     = r_send_cnt + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_send_cnt == '0) begin
                                status = STATUS_ERR;
                            end else begin
                                n_send_slot = next_slot(r_send_slot);
                                n_send_cnt  = r_send_cnt - CNT_W'(1);
                            end
                        end
                        REQ_READ: begin
                            if (r_send_cnt == '0) begin
                                status = STATUS_ERR;
                            end else begin
                                load          = 1'b0;
                                o_mem.slot_re = 1'b1;
                                n_state       = ST_LEN;
                            end
                        end
                        REQ_SET_NONCE: begin
                            if (r_enc_cnt == '0) begin
                                status = STATUS_ERR;
                            end else begin
                                o_mem.nonce_we = 1'b1;
                            end
                        end
                        default: begin
                            status = STATUS_ERR;
                        end
                    endcase
                    n_out.status   = status;
                    n_out.out_last = 1'b1;
                end
            end
            ST_LEN: begin
                o_mem.msg_re    = 1'b1;
                o_mem.msg_raddr = msg_addr(r_send_slot, '0);
                n_idx           = '0;
                n_state         = ST_BYTE;
            end
            ST_BYTE: begin
                if (out_free) begin
                    load            = 1'b1;
                    n_out.status    = STATUS_OK;
                    n_out.out_byte  = i_msg_rdata;
                    n_out.out_last  = is_last;
                    n_out.out_nonce = 64'(i_nonce_rdata);
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx           = r_idx + IDX_W'(1);
                        o_mem.msg_re    = 1'b1;
                        o_mem.msg_raddr = msg_addr(r_send_slot, n_idx);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out.pending_encrypt = 5'(n_enc_cnt);
        n_out.pending_send    = 5'(n_send_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_add_slot  <= '0;
            r_enc_slot  <= '0;
            r_send_slot <= '0;
            r_enc_cnt   <= '0;
            r_send_cnt  <= '0;
            r_bytes     <= '0;
            r_too_long  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_add_slot  <= n_add_slot;
            r_enc_slot  <= n_enc_slot;
            r_send_slot <= n_send_slot;
            r_enc_cnt   <= n_enc_cnt;
            r_send_cnt  <= n_send_cnt;
            r_bytes     <= n_bytes;
            r_too_long  <= n_too_long;
            r_idx       <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/three_stage_message_queue.sv @@
// Every request except a successful read yields its single transfer on the following
// cycle; back-to-back requests are taken every cycle while the output is not stalled.
// A successful read looks up the slot length and nonce, reads the first byte, then
// gives one transfer per message byte as the byte memory's one read port streams it.
// Reset (synchronous, active low) empties the ring; the stores are not cleared.
`timescale 1ns / 1ps

module three_stage_message_queue
    import tmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    t_mem_cmd           mem;
    logic [7:0]         msg_rdata;
    logic [LEN_W-1:0]   len_rdata;
    logic [NONCE_W-1:0] nonce_rdata;

    tmq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .o_mem         (mem),
        .i_msg_rdata   (msg_rdata),
        .i_len_rdata   (len_rdata),
        .i_nonce_rdata (nonce_rdata)
    );

    tmq_ram #(
        .WIDTH (8),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (mem.msg_we),
        .i_waddr (mem.msg_waddr),
        .i_wdata (mem.msg_wdata),
        .i_re    (mem.msg_re),
        .i_raddr (mem.msg_raddr),
        .o_rdata (msg_rdata)
    );

    tmq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (mem.len_we),
        .i_waddr (mem.len_waddr),
        .i_wdata (mem.len_wdata),
        .i_re    (mem.slot_re),
        .i_raddr (mem.slot_raddr),
        .o_rdata (len_rdata)
    );

    tmq_ram #(
        .WIDTH (NONCE_W),
        .DEPTH (SLOTS)
    ) u_nonce_ram (
        .i_clk   (i_clk),
        .i_we    (mem.nonce_we),
        .i_waddr (mem.nonce_waddr),
        .i_wdata (mem.nonce_wdata),
        .i_re    (mem.slot_re),
        .i_raddr (mem.slot_raddr),
        .o_rdata (nonce_rdata)
    );

endmodule

@@ bench/tmq_ring_checker.sv @@
`timescale 1ns / 1ps

module tmq_ring_checker
    import tmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_rsp i_out_data,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_compared
);

    logic [7:0]         ring_bytes [SLOTS][MESSAGE_BYTES];
    logic [LEN_W-1:0]   ring_len   [SLOTS];
    logic [NONCE_W-1:0] ring_nonce [SLOTS];
    logic [SLOT_W-1:0]  add_ptr;
    logic [SLOT_W-1:0]  enc_ptr;
    logic [SLOT_W-1:0]  send_ptr;
    logic [CNT_W-1:0]   enc_cnt;
    logic [CNT_W-1:0]   send_cnt;
    int                 fill;
    logic               overflow;
    t_rsp               replies_due [$];
    int                 mismatches = 0;
    int                 compared = 0;

    assign o_mismatches = mismatches;
    assign o_compared   = compared;

    function automatic logic [SLOT_W-1:0] step_ptr(input logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    task automatic report(input string msg);
        $display("%0t ns ring checker: %s", $time, msg);
        mismatches++;
    endtask

    // Updates the ring for one request and queues every transfer it must produce.
    task automatic apply_to_ring(input t_req r);
        t_rsp rsp;
        logic err;
        int   len;
        rsp = '0;
        rsp.out_last = 1'b1;
        err = 1'b0;
        len = 0;
        case (r.req_type)
            REQ_ADD: begin
                if (int'(enc_cnt) + int'(send_cnt) >= SLOTS || fill >= MESSAGE_BYTES) begin
                    overflow = 1'b1;
                end else begin
                    ring_bytes[add_ptr][fill] = r.data_byte;
                    fill++;
                end
                if (r.byte_last) begin
                    if (overflow) begin
                        err = 1'b1;
                    end else begin
                        ring_len[add_ptr] = LEN_W'(fill);
                        add_ptr = step_ptr(add_ptr);
                        enc_cnt++;
                    end
                    fill = 0;
                    overflow = 1'b0;
                end
            end
            REQ_ENCRYPTED, REQ_SET_NONCE: begin
                if (enc_cnt == 0) begin
                    err = 1'b1;
                end else begin
                    ring_nonce[enc_ptr] = r.nonce_in[NONCE_W-1:0];
                    if (r.req_type == REQ_ENCRYPTED) begin
                        enc_ptr = step_ptr(enc_ptr);
                        enc_cnt--;
                        send_cnt++;
                    end
                end
            end
            REQ_REMOVE: begin
                if (send_cnt == 0) begin
                    err = 1'b1;
                end else begin
                    send_ptr = step_ptr(send_ptr);
                    send_cnt--;
                end
            end
            REQ_READ: begin
                if (send_cnt == 0) begin
                    err = 1'b1;
                end else begin
                    len = int'(ring_len[send_ptr]);
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
        rsp.status = err ? STATUS_ERR : STATUS_OK;
        rsp.pending_encrypt = enc_cnt;
        rsp.pending_send = send_cnt;
        if (len > 0) begin
            for (int i = 0; i < len; i++) begin
                rsp.out_byte = ring_bytes[send_ptr][i];
                rsp.out_last = (i == len - 1);
                rsp.out_nonce = 64'(ring_nonce[send_ptr]);
                replies_due.push_back(rsp);
            end
        end else begin
            replies_due.push_back(rsp);
        end
    endtask

    task automatic compare_reply(input t_rsp got);
        t_rsp want;
        if (replies_due.size() == 0) begin
            report($sformatf("transfer %h arrived with nothing expected", got));
            return;
        end
        want = replies_due.pop_front();
        compared++;
        if (got.status !== want.status)
            report($sformatf("transfer %0d status %b, expected %b",
                             compared, got.status, want.status));
        if (got.out_byte !== want.out_byte)
            report($sformatf("transfer %0d out_byte %h, expected %h",
                             compared, got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
            report($sformatf("transfer %0d out_last %b, expected %b",
                             compared, got.out_last, want.out_last));
        if (got.out_nonce !== want.out_nonce)
            report($sformatf("transfer %0d out_nonce %h, expected %h",
                             compared, got.out_nonce, want.out_nonce));
        if (got.pending_encrypt !== want.pending_encrypt)
            report($sformatf("transfer %0d pending_encrypt %0d, expected %0d",
                             compared, got.pending_encrypt, want.pending_encrypt));
        if (got.pending_send !== want.pending_send)
            report($sformatf("transfer %0d pending_send %0d, expected %0d",
                             compared, got.pending_send, want.pending_send));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            add_ptr = '0;
            enc_ptr = '0;
            send_ptr = '0;
            enc_cnt = '0;
            send_cnt = '0;
            fill = 0;
            overflow = 1'b0;
            replies_due.delete();
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_reply(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                apply_to_ring(i_in_data);
            end
            o_outstanding <= replies_due.size();
        end
    end

endmodule

@@ bench/tb_three_stage_message_queue.sv @@
`timescale 1ns / 1ps

module tb_three_stage_message_queue;
    import tmq_pkg::*;

    localparam int RANDOM_ITEMS = 30;
    localparam int IDLE_LIMIT   = 400;
    localparam int SETTLE       = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_req        in_data = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_rsp        out_data;

    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;
    int unsigned rx_hold = 0;
    int unsigned rx_draw;
    int unsigned idle_run = 0;
    int          mismatches;
    int          outstanding;
    int          compared;
    int          req_seen [8];
    int          total_sent = 0;
    logic [2:0]  op_pool [4] = '{REQ_ENCRYPTED, REQ_REMOVE, REQ_READ, REQ_SET_NONCE};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    three_stage_message_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    tmq_ring_checker ring_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req make_req(input logic [2:0] kind, input logic [7:0] b,
                                      input logic last, input logic [63:0] nonce);
        t_req r;
        r.req_type = kind;
        r.data_byte = b;
        r.byte_last = last;
        r.nonce_in = nonce;
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (in_stall !== 1'b0);
        req_seen[r.req_type]++;
        total_sent++;
        if ($urandom_range(0, 15) == 0) tx_quiet = ~tx_quiet;
    endtask

    task automatic send_message(input int len, input bit mixed);
        for (int i = 0; i < len; i++) begin
            if (mixed && i != 0 && $urandom_range(0, 9) == 0) begin
                send_req(make_req(op_pool[$urandom_range(0, 3)], 8'($urandom),
                                  1'($urandom), rand64()));
            end
            send_req(make_req(REQ_ADD, 8'($urandom), i == len - 1, rand64()));
        end
    endtask

    task automatic drain_queue();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_hold <= 0;
            out_stall <= 1'b0;
        end else if (out_valid && !out_stall) begin
            rx_draw = rx_quiet ? 0 : $urandom_range(0, 3);
            rx_hold <= rx_draw;
            out_stall <= (rx_draw != 0);
            if ($urandom_range(0, 31) == 0) rx_quiet <= ~rx_quiet;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            out_stall <= (rx_hold > 1);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("tb_three_stage_message_queue: errors");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        int   start;
        int   pick;
        int   len;
        bit   paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Every stage empty, then unknown codes.
        send_req(make_req(REQ_REMOVE, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_READ, 8'hFF, 1'b1, '1));
        send_req(make_req(REQ_ENCRYPTED, 8'h00, 1'b0, '1));
        send_req(make_req(REQ_SET_NONCE, 8'hFF, 1'b1, '0));
        for (int c = int'(REQ_SET_NONCE) + 1; c < 8; c++) begin
            send_req(make_req(3'(c), 8'($urandom), 1'($urandom), rand64()));
        end

        // A one-byte message, then a two-byte one with an encrypt-done in the middle.
        send_req(make_req(REQ_ADD, 8'h00, 1'b1, '0));
        send_req(make_req(REQ_ADD, 8'hFF, 1'b0, '1));
        send_req(make_req(REQ_ENCRYPTED, 8'h00, 1'b0, '1));
        send_req(make_req(REQ_ADD, 8'h80, 1'b1, '0));
        send_req(make_req(REQ_SET_NONCE, 8'h00, 1'b0, 64'h8000_0000_0000_0001));
        send_req(make_req(REQ_ENCRYPTED, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_READ, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_REMOVE, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_READ, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_REMOVE, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_REMOVE, 8'h00, 1'b0, '0));
        send_req(make_req(REQ_READ, 8'h00, 1'b0, '0));

        drain_queue();

        // Longest message, an oversized one, then fill the ring past capacity.
        send_message(MESSAGE_BYTES, 1'b0);
        send_message(MESSAGE_BYTES + 1, 1'b0);
        repeat (SLOTS) send_message(1, 1'b0);
        send_message(2, 1'b0);
        send_req(make_req(REQ_SET_NONCE, 8'($urandom), 1'($urandom), rand64()));
        repeat (SLOTS + 1) begin
            send_req(make_req(REQ_ENCRYPTED, 8'($urandom), 1'($urandom), rand64()));
        end
        send_req(make_req(REQ_READ, 8'($urandom), 1'($urandom), rand64()));
        send_req(make_req(REQ_REMOVE, 8'($urandom), 1'($urandom), rand64()));

        start = total_sent;
        while (total_sent - start < RANDOM_ITEMS) begin
            if (!paused && total_sent - start >= RANDOM_ITEMS / 2) begin
                drain_queue();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = $urandom_range(1, 5);
                send_message(len, 1'b1);
            end else if (pick < 58) begin
                send_req(make_req(REQ_ENCRYPTED, 8'($urandom), 1'($urandom), rand64()));
            end else if (pick < 76) begin
                send_req(make_req(REQ_READ, 8'($urandom), 1'($urandom), rand64()));
            end else if (pick < 90) begin
                send_req(make_req(REQ_REMOVE, 8'($urandom), 1'($urandom), rand64()));
            end else if (pick < 95) begin
                send_req(make_req(REQ_SET_NONCE, 8'($urandom), 1'($urandom), rand64()));
            end else begin
                send_req(make_req(3'($urandom), 8'($urandom), 1'($urandom), rand64()));
            end
        end

        drain_queue();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d requests: %0d add bytes, %0d encrypt-done, %0d set-nonce,",
                 total_sent, req_seen[REQ_ADD], req_seen[REQ_ENCRYPTED],
                 req_seen[REQ_SET_NONCE]);
        $display("%0d remove, %0d read, %0d unknown codes; compared %0d transfers, %0d bad.",
                 req_seen[REQ_REMOVE], req_seen[REQ_READ],
                 total_sent - req_seen[REQ_ADD] - req_seen[REQ_ENCRYPTED]
                 - req_seen[REQ_SET_NONCE] - req_seen[REQ_REMOVE] - req_seen[REQ_READ],
                 compared, mismatches);
        if (mismatches == 0) begin
            $display("tb_three_stage_message_queue: clean");
        end else begin
            $display("tb_three_stage_message_queue: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tmq_pkg.sv
hw/rtl/tmq_ram.sv
hw/rtl/tmq_ctrl.sv
hw/rtl/three_stage_message_queue.sv
bench/tmq_ring_checker.sv
bench/tb_three_stage_message_queue.sv
